// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hdl/svm_pkg.sv
// Shared types, opcodes and status codes for the stack machine executor.
// No dependencies.
package svm_pkg;
	localparam int STACK_DEPTH = 64;
	localparam int SP_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int NUM_REGS = 4;

	localparam logic [4:0] OP_PUSH = 5'd0, OP_MOVE = 5'd1, OP_PEEK = 5'd2, OP_RETURN = 5'd3,
		OP_POP = 5'd4, OP_HALT = 5'd5, OP_PLUS = 5'd6, OP_APPEND = 5'd7, OP_APPEND_VAL = 5'd8,
		OP_MINUS = 5'd9, OP_DECR = 5'd10, OP_DECR_VAL = 5'd11, OP_DIV = 5'd12, OP_MULT = 5'd13,
		OP_LOAD = 5'd14, OP_UNLOAD = 5'd15, OP_CMP = 5'd16, OP_CMP_VAL = 5'd17, OP_JUMP = 5'd18,
		OP_JEQ = 5'd19, OP_JNE = 5'd20, OP_JGR = 5'd21, OP_JGE = 5'd22, OP_JLE = 5'd23,
		OP_JLS = 5'd24;

	localparam logic [2:0] ST_OK = 3'd0, ST_OVERFLOW = 3'd1, ST_UNDERFLOW = 3'd2,
		ST_EMPTY = 3'd3, ST_BAD_JUMP = 3'd4, ST_UNKNOWN = 3'd5, ST_DIV_ZERO = 3'd6;

	localparam logic [1:0] CF_EQ = 2'd0, CF_GT = 2'd1, CF_LT = 2'd3;

	typedef struct packed {
		logic [4:0] func;
		logic signed [63:0] immediate;
		logic [1:0] first_reg;
		logic [1:0] second_reg;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic signed [63:0] out_value;
		logic out_valid;
		logic [15:0] next_ip;
		logic halted;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load_instr;  // latch the accepted instruction, start stack read
		logic execute;     // commit one instruction (non-iterative, or iterative unit done)
		logic iter_start;  // start the iterative unit (divide or multiply)
		logic iter_step;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_iter;   // instruction needs the iterative unit
		logic iter_done;
	} dp_status_t;
endpackage

// File: hdl/svm_ctrl.sv
// Controller state machine for the stack machine executor.
// Depends on svm_pkg.
module svm_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid_o,
	input  logic out_ready,
	input  svm_pkg::dp_status_t stat,
	output svm_pkg::dp_cmd_t cmd
);
	localparam logic [1:0] S_IDLE = 2'd0, S_EXEC = 2'd1, S_DIV = 2'd2, S_OUT = 2'd3;
	logic [1:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid_o = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_instr = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.is_iter) begin
					cmd.iter_start = 1'b1;
					state_d = S_DIV;
				end else begin
					cmd.execute = 1'b1;
					state_d = S_OUT;
				end
			end
			S_DIV: begin
				if (stat.iter_done) begin
					cmd.execute = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.iter_step = 1'b1;
				end
			end
			S_OUT: begin
				out_valid_o = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

// File: hdl/svm_datapath.sv
// Datapath: operand stack memory, registers, flags, ALU, serial divider
// and multi-cycle multiplier. Depends on svm_pkg.
module svm_datapath (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [6:0] cfg_wdata,
	input  svm_pkg::in_item_t in_item,
	input  svm_pkg::dp_cmd_t cmd,
	output svm_pkg::dp_status_t stat,
	output svm_pkg::out_item_t out_item,
	output logic [svm_pkg::CNT_W-1:0] count_o
);
	localparam int CW = svm_pkg::CNT_W;
	localparam int AW = svm_pkg::SP_W;

	logic [63:0] stack_mem [svm_pkg::STACK_DEPTH];
	logic [63:0] top_q, below_q;
	logic [CW-1:0] count_q;
	logic [63:0] regs_q [svm_pkg::NUM_REGS];
	logic [1:0] cflag_q;
	logic [15:0] ip_q;
	logic halt_q;
	logic [6:0] limit_q;
	svm_pkg::in_item_t ins_q;
	svm_pkg::out_item_t res_q;

	// divider state
	logic [63:0] dq_q, drem_q, dmag_q;
	logic [6:0] dcnt_q;
	logic dneg_q;

	// multiplier state
	logic [31:0] mul_a, mul_b;
	logic [63:0] mprod, macc_q;
	logic is_mul;

	logic [CW-1:0] cap;
	always_comb begin
		if (limit_q == 7'd0) cap = CW'(1);
		else if ({1'b0, limit_q} > 8'(svm_pkg::STACK_DEPTH)) cap = CW'(svm_pkg::STACK_DEPTH);
		else cap = CW'(limit_q);
	end

	// stack read addresses follow the count; reads registered at load
	logic [AW-1:0] a_top, a_below;
	assign a_top = AW'(count_q - CW'(1));
	assign a_below = AW'(count_q - CW'(2));
	always_ff @(posedge clk) begin
		if (cmd.load_instr) begin
			top_q <= stack_mem[a_top];
			below_q <= stack_mem[a_below];
			ins_q <= in_item;
		end
	end

	logic [63:0] r1, r2, imm;
	assign r1 = regs_q[ins_q.first_reg];
	assign r2 = regs_q[ins_q.second_reg];
	assign imm = ins_q.immediate;

	assign is_mul = ins_q.func == svm_pkg::OP_MULT;
	assign stat.is_iter = count_q >= CW'(2) &&
		(is_mul || (ins_q.func == svm_pkg::OP_DIV && top_q != 64'd0));
	assign stat.iter_done = is_mul ? (dcnt_q == 7'd3) : (dcnt_q == 7'd64);

	// restoring divider, one quotient bit a cycle on magnitudes
	logic [64:0] dtrial;
	logic [63:0] drem_sh;
	assign drem_sh = {drem_q[62:0], dq_q[63]};
	assign dtrial = {1'b0, drem_sh} - {1'b0, dmag_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dcnt_q <= '0;
		else if (cmd.iter_start) dcnt_q <= '0;
		else if (cmd.iter_step) dcnt_q <= dcnt_q + 7'd1;
	end
	always_ff @(posedge clk) begin
		if (cmd.iter_start) begin
			dq_q <= below_q[63] ? 64'd0 - below_q : below_q;
			dmag_q <= top_q[63] ? 64'd0 - top_q : top_q;
			drem_q <= '0;
			dneg_q <= below_q[63] ^ top_q[63];
		end else if (cmd.iter_step) begin
			if (!dtrial[64]) begin
				drem_q <= dtrial[63:0];
				dq_q <= {dq_q[62:0], 1'b1};
			end else begin
				drem_q <= drem_sh;
				dq_q <= {dq_q[62:0], 1'b0};
			end
		end
	end

	// low 64 product bits from three 32x32 partial products, one a cycle:
	// lo*lo, then lo*hi and hi*lo shifted up 32
	always_comb begin
		if (dcnt_q == 7'd0) begin
			mul_a = below_q[31:0];
			mul_b = top_q[31:0];
		end else if (dcnt_q == 7'd1) begin
			mul_a = below_q[31:0];
			mul_b = top_q[63:32];
		end else begin
			mul_a = below_q[63:32];
			mul_b = top_q[31:0];
		end
	end
	assign mprod = 64'(mul_a) * 64'(mul_b);
	always_ff @(posedge clk) begin
		if (cmd.iter_start) macc_q <= '0;
		else if (cmd.iter_step && is_mul)
			macc_q <= macc_q + ((dcnt_q == 7'd0) ? mprod : {mprod[31:0], 32'd0});
	end

	function automatic logic [1:0] cmp3(input logic [63:0] a, input logic [63:0] b);
		if ($signed(a) > $signed(b)) return svm_pkg::CF_GT;
		if ($signed(a) < $signed(b)) return svm_pkg::CF_LT;
		return svm_pkg::CF_EQ;
	endfunction

	// one instruction's effect
	logic [2:0] st;
	logic [63:0] val, nbelow;
	logic vld, adv, taken, wr_stack, wr_reg, wr_flag, set_halt, tgt_ok;
	logic [CW-1:0] ncount;
	logic [63:0] stack_wd, reg_wd;
	logic [AW-1:0] stack_wa;
	logic [1:0] nflag;
	always_comb begin
		st = svm_pkg::ST_OK;
		val = '0;
		vld = 1'b0;
		adv = 1'b1;
		taken = 1'b0;
		wr_stack = 1'b0;
		wr_reg = 1'b0;
		wr_flag = 1'b0;
		set_halt = 1'b0;
		ncount = count_q;
		stack_wd = '0;
		stack_wa = AW'(count_q);
		reg_wd = '0;
		nflag = cflag_q;
		nbelow = '0;
		tgt_ok = !imm[63] && imm <= 64'(cap);
		unique case (ins_q.func)
			svm_pkg::OP_PUSH, svm_pkg::OP_UNLOAD: begin
				if (count_q + CW'(1) > cap || count_q == CW'(svm_pkg::STACK_DEPTH))
					st = svm_pkg::ST_OVERFLOW;
				else begin
					wr_stack = 1'b1;
					stack_wd = (ins_q.func == svm_pkg::OP_PUSH) ? imm : r1;
					ncount = count_q + CW'(1);
				end
			end
			svm_pkg::OP_MOVE: begin wr_reg = 1'b1; reg_wd = imm; end
			svm_pkg::OP_PEEK: begin
				if (count_q == '0) st = svm_pkg::ST_EMPTY;
				else begin val = top_q; vld = 1'b1; end
			end
			svm_pkg::OP_RETURN: begin val = r1; vld = 1'b1; end
			svm_pkg::OP_POP: begin
				if (count_q == '0) st = svm_pkg::ST_EMPTY;
				else ncount = count_q - CW'(1);
			end
			svm_pkg::OP_HALT: begin set_halt = 1'b1; adv = 1'b0; end
			svm_pkg::OP_PLUS, svm_pkg::OP_MINUS, svm_pkg::OP_DIV, svm_pkg::OP_MULT: begin
				if (count_q < CW'(2)) st = svm_pkg::ST_UNDERFLOW;
				else if (ins_q.func == svm_pkg::OP_DIV && top_q == '0) st = svm_pkg::ST_DIV_ZERO;
				else begin
					priority case (ins_q.func)
						svm_pkg::OP_PLUS: nbelow = below_q + top_q;
						svm_pkg::OP_MINUS: nbelow = below_q - top_q;
						svm_pkg::OP_DIV: nbelow = dneg_q ? 64'd0 - dq_q : dq_q;
						default: nbelow = macc_q;
					endcase
					wr_stack = 1'b1;
					stack_wd = nbelow;
					stack_wa = AW'(count_q - CW'(2));
					ncount = count_q - CW'(1);
				end
			end
			svm_pkg::OP_APPEND, svm_pkg::OP_DECR, svm_pkg::OP_LOAD: begin
				if (count_q == '0) st = svm_pkg::ST_EMPTY;
				else begin
					wr_reg = 1'b1;
					priority case (ins_q.func)
						svm_pkg::OP_APPEND: reg_wd = r1 + top_q;
						svm_pkg::OP_DECR: reg_wd = r1 - top_q;
						default: reg_wd = top_q;
					endcase
					ncount = count_q - CW'(1);
				end
			end
			svm_pkg::OP_APPEND_VAL: begin wr_reg = 1'b1; reg_wd = r1 + imm; end
			svm_pkg::OP_DECR_VAL: begin wr_reg = 1'b1; reg_wd = r1 - imm; end
			svm_pkg::OP_CMP: begin wr_flag = 1'b1; nflag = cmp3(r1, r2); end
			svm_pkg::OP_CMP_VAL: begin wr_flag = 1'b1; nflag = cmp3(r1, imm); end
			svm_pkg::OP_JUMP, svm_pkg::OP_JEQ, svm_pkg::OP_JNE, svm_pkg::OP_JGR,
			svm_pkg::OP_JGE, svm_pkg::OP_JLE, svm_pkg::OP_JLS: begin
				if (!tgt_ok) st = svm_pkg::ST_BAD_JUMP;
				else begin
					priority case (ins_q.func)
						svm_pkg::OP_JUMP: taken = 1'b1;
						svm_pkg::OP_JEQ: taken = cflag_q == svm_pkg::CF_EQ;
						svm_pkg::OP_JNE: taken = cflag_q != svm_pkg::CF_EQ;
						svm_pkg::OP_JGR: taken = cflag_q == svm_pkg::CF_GT;
						svm_pkg::OP_JGE: taken = cflag_q != svm_pkg::CF_LT;
						svm_pkg::OP_JLE: taken = cflag_q != svm_pkg::CF_GT;
						default: taken = cflag_q == svm_pkg::CF_LT;
					endcase
					if (taken) adv = 1'b0;
				end
			end
			default: st = svm_pkg::ST_UNKNOWN;
		endcase
	end

	logic [15:0] nip;
	assign nip = (st != svm_pkg::ST_OK) ? ip_q :
		(taken ? imm[15:0] : (adv ? ip_q + 16'd1 : ip_q));

	always_ff @(posedge clk) begin
		if (cmd.execute && wr_stack) stack_mem[stack_wa] <= stack_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < svm_pkg::NUM_REGS; i++) regs_q[i] <= '0;
			cflag_q <= svm_pkg::CF_EQ;
			ip_q <= '0;
			halt_q <= 1'b0;
			limit_q <= 7'd64;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (cmd.execute) begin
				count_q <= ncount;
				if (wr_reg) regs_q[ins_q.first_reg] <= reg_wd;
				if (wr_flag) cflag_q <= nflag;
				ip_q <= nip;
				if (set_halt) halt_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			res_q.status <= st;
			res_q.out_value <= val;
			res_q.out_valid <= vld;
			res_q.next_ip <= nip;
			res_q.halted <= halt_q | set_halt;
		end
	end

	assign out_item = res_q;
	assign count_o = count_q;
endmodule

// File: hdl/stack_vm_instruction_execute.sv
// Stack machine instruction executor, top level: controller plus datapath.
// Depends on svm_pkg, svm_ctrl, svm_datapath and assert_macros.svh.
//
// Executes one instruction per transfer on in_*, returning one result per
// instruction on out_*. An instruction passes through the accept, execute
// and present states in order: the result is registered at execute and
// valid in the present state, and the next input is accepted the cycle
// after the result transfer. A divide first runs all 64 quotient bits of the
// restoring divider and a multiply its three 32x32 partial products before
// the commit. The operand stack is a memory read at the accept edge (top
// and next entry) and written once at commit. One instruction is in flight
// at a time, since each depends on the stack and flags that the previous
// one leaves. stack_limit must be written through cfg_we/cfg_wdata only
// while no instruction is in flight; the block itself does not enforce it.
`include "assert_macros.svh"
module stack_vm_instruction_execute (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  svm_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output svm_pkg::out_item_t out_data
);
	svm_pkg::dp_cmd_t cmd;
	svm_pkg::dp_status_t stat;
	logic [svm_pkg::CNT_W-1:0] count;

	svm_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready,
		.out_valid_o(out_valid), .out_ready, .stat, .cmd
	);

	svm_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .in_item(in_data),
		.cmd, .stat, .out_item(out_data), .count_o(count)
	);

	// never accept while a result is pending
	`ASSERT_IMPL(a_no_overlap, out_valid, !in_ready)
	// a commit always leads to a presented result
	`ASSERT_NEXT(a_exec_out, cmd.execute, out_valid)
	// stack never exceeds its storage
	`ASSERT_IMPL(a_count_bound, 1'b1, count <= (svm_pkg::CNT_W)'(svm_pkg::STACK_DEPTH))
endmodule
